/* rtl/fisr_pkg.sv */
package fisr_pkg;

	localparam int MW = 50;
	localparam int LATENCY = 21;

	localparam logic [31:0] RSQRT_MAGIC = 32'h5f375a86;
	localparam logic [31:0] CANON_QNAN = 32'h7fc00000;
	localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
	localparam logic [31:0] SIGN_MASK = 32'h80000000;

	// Unpacked operand: subnormals carry an exponent of one and no hidden bit.
	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
		logic [7:0] exp;
		logic [23:0] mant;
	} fp_unp_t;

	// Exact value to round: (-1)^sign * mant * 2^exp, unless a special flag is set.
	typedef struct packed {
		logic valid;
		logic sign;
		logic nan;
		logic inf;
		logic zero;
		logic signed [10:0] exp;
		logic [MW-1:0] mant;
		logic [31:0] side;
	} rnd_in_t;

	typedef struct packed {
		logic valid;
		logic [31:0] bits;
		logic [31:0] side;
	} rnd_out_t;

	typedef struct packed {
		logic valid;
		logic nan;
		logic inf;
		logic sign;
		logic sub;
		logic signed [10:0] exp;
		logic [MW-1:0] mant_big;
		logic [MW-1:0] mant_small;
		logic [31:0] side;
	} add_al_t;

	function automatic fp_unp_t unpack(input logic [31:0] f);
		fp_unp_t u;
		u.nan = (&f[30:23]) && (|f[22:0]);
		u.inf = (&f[30:23]) && !(|f[22:0]);
		u.zero = (f[30:0] == 31'd0);
		u.exp = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
		u.mant = {|f[30:23], f[22:0]};
		return u;
	endfunction

	function automatic rnd_in_t half_prep(input logic valid, input logic [31:0] a,
			input logic [31:0] side);
		fp_unp_t u;
		rnd_in_t r;
		u = unpack(a);
		r.valid = valid;
		r.sign = a[31];
		r.nan = u.nan;
		r.inf = u.inf;
		r.zero = u.zero;
		r.exp = $signed({3'b000, u.exp}) - 11'sd151;
		r.mant = {26'd0, u.mant};
		r.side = side;
		return r;
	endfunction

	function automatic rnd_in_t mul_prep(input logic valid, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] side);
		fp_unp_t ua;
		fp_unp_t ub;
		rnd_in_t r;
		ua = unpack(a);
		ub = unpack(b);
		r.valid = valid;
		r.sign = a[31] ^ b[31];
		r.nan = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
		r.inf = ua.inf | ub.inf;
		r.zero = ua.zero | ub.zero;
		r.exp = $signed({3'b000, ua.exp}) + $signed({3'b000, ub.exp}) - 11'sd300;
		r.mant = {2'b00, {24'd0, ua.mant} * {24'd0, ub.mant}};
		r.side = side;
		return r;
	endfunction

	function automatic add_al_t add_align(input logic valid, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] side);
		fp_unp_t ua;
		fp_unp_t ub;
		fp_unp_t ubig;
		fp_unp_t usml;
		logic a_big;
		logic [8:0] diff;
		logic [5:0] sh;
		logic [2*MW-1:0] t;
		add_al_t r;
		ua = unpack(a);
		ub = unpack(b);
		a_big = (a[30:0] >= b[30:0]);
		ubig = a_big ? ua : ub;
		usml = a_big ? ub : ua;
		diff = {1'b0, ubig.exp} - {1'b0, usml.exp};
		sh = (diff > 9'd63) ? 6'd63 : diff[5:0];
		t = {1'b0, usml.mant, 25'd0, {MW{1'b0}}} >> sh;
		r.valid = valid;
		r.sub = a[31] ^ b[31];
		r.nan = ua.nan | ub.nan | (ua.inf & ub.inf & r.sub);
		r.inf = ua.inf | ub.inf;
		// An infinity is always the larger operand, so its sign wins.
		r.sign = a_big ? a[31] : b[31];
		r.exp = $signed({3'b000, ubig.exp}) - 11'sd175;
		r.mant_big = {1'b0, ubig.mant, 25'd0};
		r.mant_small = t[2*MW-1:MW] | {{(MW-1){1'b0}}, |t[MW-1:0]};
		r.side = side;
		return r;
	endfunction

	function automatic rnd_in_t add_sum(input add_al_t al);
		rnd_in_t r;
		r.valid = al.valid;
		r.nan = al.nan;
		r.inf = al.inf;
		r.zero = 1'b0;
		r.exp = al.exp;
		r.mant = al.sub ? (al.mant_big - al.mant_small) : (al.mant_big + al.mant_small);
		// Exact cancellation gives positive zero under round to nearest.
		r.sign = (al.sub && r.mant == '0) ? 1'b0 : al.sign;
		r.side = al.side;
		return r;
	endfunction

	function automatic logic [5:0] lead_zeros(input logic [MW-1:0] m);
		logic [5:0] lz;
		lz = '0;
		for (int i = 0; i < MW; i++) begin
			if (m[i]) begin
				lz = 6'(MW - 1 - i);
			end
		end
		return lz;
	endfunction

endpackage

/* rtl/fisr_round.sv */
module fisr_round (
	input logic clk,
	input logic arst_n,
	input fisr_pkg::rnd_in_t din,
	output fisr_pkg::rnd_out_t dout
);

	logic valid_s1, sign_s1, nan_s1, inf_s1, zero_s1;
	logic signed [10:0] exp_s1;
	logic [fisr_pkg::MW-1:0] mant_s1;
	logic [5:0] lz_s1;
	logic [31:0] side_s1;

	logic valid_s2, sign_s2, nan_s2, inf_s2, zero_s2;
	logic signed [10:0] eb_s2;
	logic [6:0] d_s2;
	logic [fisr_pkg::MW-1:0] mn_s2;
	logic [31:0] side_s2;

	logic signed [10:0] be;
	logic signed [10:0] eb;
	logic [10:0] dd;
	logic [2*fisr_pkg::MW-1:0] xs;
	logic [23:0] kept;
	logic guard, sticky, inc;
	logic [10:0] em1;
	logic [31:0] sum;
	logic [31:0] bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			dout <= '0;
		end else begin
			valid_s1 <= din.valid;
			valid_s2 <= valid_s1;
			dout.valid <= valid_s2;
			dout.bits <= bits;
			dout.side <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		sign_s1 <= din.sign;
		nan_s1 <= din.nan;
		inf_s1 <= din.inf;
		zero_s1 <= din.zero | (din.mant == '0);
		exp_s1 <= din.exp;
		mant_s1 <= din.mant;
		lz_s1 <= fisr_pkg::lead_zeros(din.mant);
		side_s1 <= din.side;

		sign_s2 <= sign_s1;
		nan_s2 <= nan_s1;
		inf_s2 <= inf_s1;
		zero_s2 <= zero_s1;
		eb_s2 <= eb;
		d_s2 <= (dd >= 11'd49) ? 7'd75 : 7'(dd + 11'd26);
		mn_s2 <= mant_s1 << lz_s1;
		side_s2 <= side_s1;
	end

	// Biased exponent of the leading one; below one the value goes subnormal.
	always_comb begin
		be = exp_s1 + 11'sd176 - $signed({5'b00000, lz_s1});
		eb = (be < 11'sd1) ? 11'sd1 : be;
		dd = 11'(eb - be);
	end

	always_comb begin
		xs = {mn_s2, {fisr_pkg::MW{1'b0}}} >> d_s2;
		kept = xs[fisr_pkg::MW+23:fisr_pkg::MW];
		guard = xs[fisr_pkg::MW-1];
		sticky = |xs[fisr_pkg::MW-2:0];
		inc = guard & (sticky | kept[0]);
		em1 = 11'(eb_s2 - 11'sd1);
		// A carry out of the significand moves straight into the exponent field.
		sum = {1'b0, em1[7:0], 23'd0} + {8'd0, kept} + {31'd0, inc};
		if (nan_s2) begin
			bits = fisr_pkg::CANON_QNAN;
		end else if (inf_s2 || eb_s2 >= 11'sd255 || sum[31] || (&sum[30:23])) begin
			bits = {sign_s2, 8'hff, 23'd0};
		end else if (zero_s2) begin
			bits = {sign_s2, 31'd0};
		end else begin
			bits = {sign_s2, sum[30:0]};
		end
	end

endmodule

/* rtl/fast_inverse_square_root.sv */
// Approximate reciprocal square root of an IEEE-754 single-precision value.
// Input: drive operand_bits and raise start; a beat is taken at every clock
// edge where start is high and busy is low. busy is always low, so a new
// operand can be taken on every cycle.
// Output: done is high for exactly one cycle with approx_rsqrt_bits valid in
// that cycle. Results leave in the order the operands came in.
// Throughput is one result per cycle. The pipeline is a chain of
// single-precision operations (halving, three multiplies, one subtract),
// each made of a prepare stage (align and sum stages for the subtract) and
// a three-stage normalize-and-round unit; the 24x24 multiplier stages set
// the per-stage depth.
// Reset clears every valid bit; nothing is in flight afterwards.
// The receiver cannot hold results off, so the pipeline never stalls.
// Any NaN result is given as the canonical quiet NaN 0x7fc00000.
module fast_inverse_square_root (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] operand_bits,
	output logic done,
	output logic [31:0] approx_rsqrt_bits
);

	logic valid_s1;
	logic [31:0] x_s1;
	logic [31:0] y_s1;
	fisr_pkg::rnd_out_t half_q, t1_q, t2_q, t3_q, res_q;
	fisr_pkg::rnd_in_t m1_s5, m2_s9, sm_s14, m3_s18;
	fisr_pkg::add_al_t al_s13;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			x_s1 <= '0;
			y_s1 <= '0;
			m1_s5 <= '0;
			m2_s9 <= '0;
			al_s13 <= '0;
			sm_s14 <= '0;
			m3_s18 <= '0;
		end else begin
			valid_s1 <= start && !busy;
			x_s1 <= operand_bits;
			y_s1 <= fisr_pkg::RSQRT_MAGIC - {operand_bits[31], operand_bits[31:1]};
			m1_s5 <= fisr_pkg::mul_prep(half_q.valid, half_q.bits, half_q.side, half_q.side);
			m2_s9 <= fisr_pkg::mul_prep(t1_q.valid, t1_q.bits, t1_q.side, t1_q.side);
			al_s13 <= fisr_pkg::add_align(t2_q.valid, fisr_pkg::THREE_HALVES,
				t2_q.bits ^ fisr_pkg::SIGN_MASK, t2_q.side);
			sm_s14 <= fisr_pkg::add_sum(al_s13);
			m3_s18 <= fisr_pkg::mul_prep(t3_q.valid, t3_q.side, t3_q.bits, t3_q.side);
		end
	end

	// The guess y rides along in the side field of every rounding unit.
	fisr_round u_half (
		.clk(clk), .arst_n(arst_n),
		.din(fisr_pkg::half_prep(valid_s1, x_s1, y_s1)), .dout(half_q)
	);
	fisr_round u_t1 (.clk(clk), .arst_n(arst_n), .din(m1_s5), .dout(t1_q));
	fisr_round u_t2 (.clk(clk), .arst_n(arst_n), .din(m2_s9), .dout(t2_q));
	fisr_round u_t3 (.clk(clk), .arst_n(arst_n), .din(sm_s14), .dout(t3_q));
	fisr_round u_res (.clk(clk), .arst_n(arst_n), .din(m3_s18), .dout(res_q));

	assign done = res_q.valid;
	assign approx_rsqrt_bits = res_q.bits;

`ifndef SYNTHESIS
	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, fisr_pkg::LATENCY))
		else $error("result strobe without a matching input beat");

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (&approx_rsqrt_bits[30:23]) && (|approx_rsqrt_bits[22:0]))
		|-> approx_rsqrt_bits == fisr_pkg::CANON_QNAN)
		else $error("NaN result is not canonical");

	a_nan_in_nan_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (&operand_bits[30:23]) && (|operand_bits[22:0]),
			fisr_pkg::LATENCY))
		|-> approx_rsqrt_bits == fisr_pkg::CANON_QNAN)
		else $error("NaN operand did not give a NaN result");
`endif

endmodule
